// ===== hw/rtl/rsb_pkg.sv =====
// ----------------------------------------------------------------------------
// rsb_pkg
// Shared widths, constants and controller/datapath interface types for the
// room scheduler.
// ----------------------------------------------------------------------------
package rsb_pkg;

    localparam int START_W = 32;
    localparam int TIME_W  = 48;
    localparam int COUNT_W = 32;
    localparam int CFG_W   = 5;
    localparam int ROOM_W  = 4;

    localparam logic [CFG_W-1:0]   ROOMS_RESET = 5'd16;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
    localparam logic [TIME_W-1:0]  TIME_MAX    = '1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;    // capture the request and clear the scan state
        logic issue;   // read the next room's free time
        logic pick;    // choose the room, form the times, read its count
        logic commit;  // write back the room and load the result register
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic scan_last;  // the read being issued is the last active room
        logic out_free;   // result register can take a new result this cycle
    } t_sts;

endpackage

// ===== hw/rtl/rsb_ctrl.sv =====
// ----------------------------------------------------------------------------
// rsb_ctrl
// Sequencer for one request: accept, scan all active rooms, drain, pick, commit.
// ----------------------------------------------------------------------------
module rsb_ctrl import rsb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_sts i_sts,
    output logic o_ready,
    output t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_PICK  = 3'd3;
    localparam logic [2:0] S_UPD   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // Next state and commands
    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_ready      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
                if (i_valid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.issue = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_PICK;
            end
            S_PICK: begin
                o_cmd.pick = 1'b1;
                n_state    = S_UPD;
            end
            S_UPD: begin
                // hold until the result register is free
                o_cmd.commit = i_sts.out_free;
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== hw/rtl/rsb_dp.sv =====
// ----------------------------------------------------------------------------
// rsb_dp
// Room tables, scan comparator, time/count update and result register.
// ----------------------------------------------------------------------------
module rsb_dp import rsb_pkg::*; #(
    parameter int MAX_ROOMS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CFG_W-1:0]   i_cfg_wdata,
    input  logic [START_W-1:0] i_start_time,
    input  logic [START_W-1:0] i_end_time,
    input  t_cmd               i_cmd,
    input  logic               i_ready,
    output t_sts               o_sts,
    output logic               o_valid,
    output logic [ROOM_W-1:0]  o_room,
    output logic               o_delayed,
    output logic [TIME_W-1:0]  o_actual_start,
    output logic [TIME_W-1:0]  o_actual_end,
    output logic [ROOM_W-1:0]  o_busiest_room,
    output logic [COUNT_W-1:0] o_busiest_count
);

    localparam int IW = (MAX_ROOMS > 1) ? $clog2(MAX_ROOMS) : 1;

    // Room tables; an entry never written reads as zero
    logic [TIME_W-1:0]    r_ft_mem  [MAX_ROOMS];
    logic [COUNT_W-1:0]   r_cnt_mem [MAX_ROOMS];
    logic [MAX_ROOMS-1:0] r_ft_vld;
    logic [MAX_ROOMS-1:0] r_cnt_vld;

    logic [CFG_W-1:0]   r_rooms;
    logic [START_W-1:0] r_start;
    logic [START_W-1:0] r_dur;
    logic [IW-1:0]      r_addr;
    logic [IW-1:0]      r_rd_idx;
    logic               r_rd_vld;
    logic [TIME_W-1:0]  r_ft_q;
    logic               r_ft_qv;
    logic               r_found;
    logic [IW-1:0]      r_free_idx;
    logic               r_first;
    logic [TIME_W-1:0]  r_min;
    logic [IW-1:0]      r_min_idx;
    logic [IW-1:0]      r_pick;
    logic               r_late;
    logic [TIME_W-1:0]  r_begin;
    logic [TIME_W-1:0]  r_finish;
    logic [COUNT_W-1:0] r_cnt_q;
    logic               r_cnt_qv;
    logic [IW-1:0]      r_best_room;
    logic [COUNT_W-1:0] r_best_cnt;
    logic               r_out_vld;
    logic [IW-1:0]      r_out_room;
    logic               r_out_late;
    logic [TIME_W-1:0]  r_out_start;
    logic [TIME_W-1:0]  r_out_end;
    logic [IW-1:0]      r_out_best;
    logic [COUNT_W-1:0] r_out_bcnt;

    logic [8:0]         w_last9;
    logic [IW-1:0]      w_last;
    logic [TIME_W-1:0]  w_ft;
    logic [IW-1:0]      w_pick;
    logic [TIME_W-1:0]  w_begin;
    logic [TIME_W:0]    w_sum;
    logic [COUNT_W-1:0] w_cnt;
    logic [COUNT_W-1:0] w_cnt_new;
    logic               w_better;

    // Clamp the room count to 1..MAX_ROOMS and form the last index
    always_comb begin
        priority if (r_rooms == '0) begin
            w_last9 = '0;
        end else if (9'(r_rooms) > 9'(MAX_ROOMS)) begin
            w_last9 = 9'(MAX_ROOMS - 1);
        end else begin
            w_last9 = 9'(r_rooms) - 9'd1;
        end
    end
    assign w_last = w_last9[IW-1:0];

    // Scan data, pick and the saturating end time
    assign w_ft    = r_ft_qv ? r_ft_q : '0;
    assign w_pick  = r_found ? r_free_idx : r_min_idx;
    assign w_begin = r_found ? TIME_W'(r_start) : r_min;
    assign w_sum   = {1'b0, w_begin} + (TIME_W + 1)'(r_dur);

    // Saturating count and busiest-room test
    assign w_cnt     = r_cnt_qv ? r_cnt_q : '0;
    assign w_cnt_new = (w_cnt == COUNT_MAX) ? w_cnt : w_cnt + COUNT_W'(1);
    assign w_better  = (w_cnt_new > r_best_cnt) ||
                       ((w_cnt_new == r_best_cnt) && (r_pick < r_best_room));

    assign o_sts.scan_last = (r_addr == w_last);
    assign o_sts.out_free  = !r_out_vld || i_ready;

    // Memory ports: scan read, count read, commit write
    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_ft_q <= r_ft_mem[r_addr];
        end
        if (i_cmd.pick) begin
            r_cnt_q <= r_cnt_mem[w_pick];
        end
        if (i_cmd.commit) begin
            r_ft_mem[r_pick]  <= r_finish;
            r_cnt_mem[r_pick] <= w_cnt_new;
        end
    end

    // Request capture, scan compare, pick and result capture (payload, no reset)
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_start <= i_start_time;
            r_dur   <= (i_end_time > i_start_time) ? i_end_time - i_start_time : '0;
        end
        if (i_cmd.issue) begin
            r_ft_qv  <= r_ft_vld[r_addr];
            r_rd_idx <= r_addr;
        end
        if (r_rd_vld) begin
            if (!r_found && (w_ft <= TIME_W'(r_start))) begin
                r_free_idx <= r_rd_idx;
            end
            if (r_first || (w_ft < r_min)) begin
                r_min     <= w_ft;
                r_min_idx <= r_rd_idx;
            end
        end
        if (i_cmd.pick) begin
            r_pick   <= w_pick;
            r_late   <= !r_found;
            r_begin  <= w_begin;
            r_finish <= w_sum[TIME_W] ? TIME_MAX : w_sum[TIME_W-1:0];
            r_cnt_qv <= r_cnt_vld[w_pick];
        end
        if (i_cmd.commit) begin
            r_out_room  <= r_pick;
            r_out_late  <= r_late;
            r_out_start <= r_begin;
            r_out_end   <= r_finish;
            r_out_best  <= w_better ? r_pick : r_best_room;
            r_out_bcnt  <= w_better ? w_cnt_new : r_best_cnt;
        end
    end

    // Control state: config, scan progress, valid bits, best room, result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rooms     <= ROOMS_RESET;
            r_addr      <= '0;
            r_rd_vld    <= 1'b0;
            r_found     <= 1'b0;
            r_first     <= 1'b1;
            r_ft_vld    <= '0;
            r_cnt_vld   <= '0;
            r_best_room <= '0;
            r_best_cnt  <= '0;
            r_out_vld   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_rooms <= i_cfg_wdata;
            end
            r_rd_vld <= i_cmd.issue;
            if (i_cmd.load) begin
                r_addr  <= '0;
                r_found <= 1'b0;
                r_first <= 1'b1;
            end else begin
                if (i_cmd.issue) begin
                    r_addr <= r_addr + IW'(1);
                end
                if (r_rd_vld) begin
                    r_first <= 1'b0;
                    if (w_ft <= TIME_W'(r_start)) begin
                        r_found <= 1'b1;
                    end
                end
            end
            if (i_cmd.commit) begin
                r_ft_vld[r_pick]  <= 1'b1;
                r_cnt_vld[r_pick] <= 1'b1;
                if (w_better) begin
                    r_best_room <= r_pick;
                    r_best_cnt  <= w_cnt_new;
                end
            end
            // hold the result until its transfer
            if (i_cmd.commit) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_valid         = r_out_vld;
    assign o_room          = ROOM_W'(r_out_room);
    assign o_delayed       = r_out_late;
    assign o_actual_start  = r_out_start;
    assign o_actual_end    = r_out_end;
    assign o_busiest_room  = ROOM_W'(r_out_best);
    assign o_busiest_count = r_out_bcnt;

endmodule

// ===== hw/rtl/room_scheduler_busiest.sv =====
// ----------------------------------------------------------------------------
// room_scheduler_busiest
// Meeting-room allocator: each request goes to the lowest free room, or is
// postponed to the room that frees earliest; reports the busiest room so far.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid/o_ready) carries start and end times; requests
//   should come in nondecreasing start order. Output channel
//   (o_valid/i_ready) returns one result per request: room, delayed flag,
//   actual start/end, busiest room and its use count.
//   i_cfg_we/i_cfg_wdata set the number of active rooms (0 acts as 1, values
//   above MAX_ROOMS act as MAX_ROOMS); write only while no request is open.
//   Steps per request, N the active room count: accept, then a scan of the
//   N rooms reading one room free time per cycle through the single table
//   read port, then drain, pick and commit. A new request is accepted only
//   after the previous one has committed its result.
//   Reset clears all room free times, use counts and the busiest room at
//   once, and sets the room count to 16.
//   The result register holds its contents while i_ready is low; the next
//   request is accepted and scanned meanwhile and waits at commit for a free
//   result register.
// ----------------------------------------------------------------------------
module room_scheduler_busiest import rsb_pkg::*; #(
    parameter int MAX_ROOMS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CFG_W-1:0]   i_cfg_wdata,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [START_W-1:0] i_start_time,
    input  logic [START_W-1:0] i_end_time,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [ROOM_W-1:0]  o_room,
    output logic               o_delayed,
    output logic [TIME_W-1:0]  o_actual_start,
    output logic [TIME_W-1:0]  o_actual_end,
    output logic [ROOM_W-1:0]  o_busiest_room,
    output logic [COUNT_W-1:0] o_busiest_count
);

    t_cmd w_cmd;
    t_sts w_sts;

    // Sequencer
    rsb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (w_sts),
        .o_ready (o_ready),
        .o_cmd   (w_cmd)
    );

    // Tables and arithmetic
    rsb_dp #(
        .MAX_ROOMS (MAX_ROOMS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_start_time    (i_start_time),
        .i_end_time      (i_end_time),
        .i_cmd           (w_cmd),
        .i_ready         (i_ready),
        .o_sts           (w_sts),
        .o_valid         (o_valid),
        .o_room          (o_room),
        .o_delayed       (o_delayed),
        .o_actual_start  (o_actual_start),
        .o_actual_end    (o_actual_end),
        .o_busiest_room  (o_busiest_room),
        .o_busiest_count (o_busiest_count)
    );

endmodule

// ===== verif/room_booking_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// room_booking_checker
// Watches the request, result and room-count ports of the room scheduler,
// books every accepted request on its own copy of the room table and compares
// each returned result, in order and field by field, with the booking it made.
// ----------------------------------------------------------------------------
module room_booking_checker import rsb_pkg::*; #(
    parameter int MAX_ROOMS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CFG_W-1:0]   i_cfg_wdata,
    input  logic               i_valid,
    input  logic               i_ready_in,
    input  logic [START_W-1:0] i_start_time,
    input  logic [START_W-1:0] i_end_time,
    input  logic               i_out_valid,
    input  logic               i_ready,
    input  logic [ROOM_W-1:0]  i_room,
    input  logic               i_delayed,
    input  logic [TIME_W-1:0]  i_actual_start,
    input  logic [TIME_W-1:0]  i_actual_end,
    input  logic [ROOM_W-1:0]  i_busiest_room,
    input  logic [COUNT_W-1:0] i_busiest_count,
    output int                 o_fail_count,
    output int                 o_pending
);

    typedef struct packed {
        logic [ROOM_W-1:0]  room;
        logic               delayed;
        logic [TIME_W-1:0]  act_start;
        logic [TIME_W-1:0]  act_end;
        logic [ROOM_W-1:0]  top_room;
        logic [COUNT_W-1:0] top_count;
    } t_booking;

    // Shadow room table
    logic [CFG_W-1:0]   rooms_cfg;
    logic [TIME_W-1:0]  free_at [MAX_ROOMS];
    logic [COUNT_W-1:0] uses [MAX_ROOMS];
    logic [ROOM_W-1:0]  top_room;
    logic [COUNT_W-1:0] top_count;
    t_booking           booked_q [$];
    int                 mismatches = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        mismatches++;
    endtask

    task automatic compare_field(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", field, got, want));
        end
    endtask

    // Book one request on the shadow table and return the result it must give
    function automatic t_booking book_room(input logic [START_W-1:0] req_start,
                                           input logic [START_W-1:0] req_end);
        t_booking          b;
        int                active;
        int                pick;
        bit                found;
        logic [TIME_W-1:0] span;
        logic [TIME_W:0]   sum;
        active = (rooms_cfg == 0) ? 1 : ((rooms_cfg > MAX_ROOMS) ? MAX_ROOMS : rooms_cfg);
        span   = (req_end > req_start) ? TIME_W'(req_end - req_start) : '0;
        found  = 1'b0;
        pick   = 0;
        // lowest room already free at the requested start
        for (int i = 0; i < active; i++) begin
            if (!found && free_at[i] <= TIME_W'(req_start)) begin
                pick  = i;
                found = 1'b1;
            end
        end
        // otherwise the room that frees earliest, lowest index on ties
        if (!found) begin
            for (int i = 1; i < active; i++) begin
                if (free_at[i] < free_at[pick]) begin
                    pick = i;
                end
            end
        end
        b.room      = ROOM_W'(pick);
        b.delayed   = !found;
        b.act_start = found ? TIME_W'(req_start) : free_at[pick];
        sum         = {1'b0, b.act_start} + {1'b0, span};
        b.act_end   = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
        free_at[pick] = b.act_end;
        if (uses[pick] != COUNT_MAX) begin
            uses[pick]++;
        end
        if (uses[pick] > top_count || (uses[pick] == top_count && pick < top_room)) begin
            top_count = uses[pick];
            top_room  = ROOM_W'(pick);
        end
        b.top_room  = top_room;
        b.top_count = top_count;
        return b;
    endfunction

    // Track transfers: book on request, compare on result
    always @(posedge i_clk) begin
        t_booking want;
        if (!i_rst_n) begin
            rooms_cfg = ROOMS_RESET;
            for (int i = 0; i < MAX_ROOMS; i++) begin
                free_at[i] = '0;
                uses[i]    = '0;
            end
            top_room  = '0;
            top_count = '0;
            booked_q.delete();
        end else begin
            if (i_cfg_we) begin
                rooms_cfg = i_cfg_wdata;
            end
            if (i_valid && i_ready_in) begin
                booked_q.push_back(book_room(i_start_time, i_end_time));
            end
            if (i_out_valid && i_ready) begin
                if (booked_q.size() == 0) begin
                    report_mismatch($sformatf("result for room %0d with no request open",
                                              i_room));
                end else begin
                    want = booked_q.pop_front();
                    compare_field("room", i_room, want.room);
                    compare_field("delayed", i_delayed, want.delayed);
                    compare_field("actual_start", i_actual_start, want.act_start);
                    compare_field("actual_end", i_actual_end, want.act_end);
                    compare_field("busiest_room", i_busiest_room, want.top_room);
                    compare_field("busiest_count", i_busiest_count, want.top_count);
                end
            end
        end
        o_pending    <= booked_q.size();
        o_fail_count <= mismatches;
    end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives booking requests into the room scheduler under several room counts:
// a short directed set for free, postponed, tied and out-of-order bookings,
// then streams of rising start times with random spacing and durations mixed
// with out-of-order noise. Both channels stall at random, with one long
// result hold-off. The checker beside the block scores every result.
// ----------------------------------------------------------------------------
module testbench;
    import rsb_pkg::*;

    localparam int MAX_ROOMS    = 16;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 154;
    localparam int DRAIN_CYCLES = 40;
    localparam int RUN_LIMIT    = 600000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [CFG_W-1:0]   i_cfg_wdata = '0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [START_W-1:0] i_start_time = '0;
    logic [START_W-1:0] i_end_time = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [ROOM_W-1:0]  o_room;
    logic               o_delayed;
    logic [TIME_W-1:0]  o_actual_start;
    logic [TIME_W-1:0]  o_actual_end;
    logic [ROOM_W-1:0]  o_busiest_room;
    logic [COUNT_W-1:0] o_busiest_count;

    int                 fail_count;
    int                 pending;
    logic               calm = 1'b0;
    logic [START_W-1:0] sched_time = 32'h8000_0200;
    int                 cycles = 0;
    int                 results_taken = 0;
    int                 hold_left = 0;
    bit                 hold_done = 1'b0;
    logic [CFG_W-1:0]   plan [PHASES] = '{5'd16, 5'd5, 5'd2, 5'd31, 5'd8,
                                          5'd1, 5'd0, 5'd3, 5'd12, 5'd16};

    room_scheduler_busiest #(.MAX_ROOMS(MAX_ROOMS)) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_start_time    (i_start_time),
        .i_end_time      (i_end_time),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_room          (o_room),
        .o_delayed       (o_delayed),
        .o_actual_start  (o_actual_start),
        .o_actual_end    (o_actual_end),
        .o_busiest_room  (o_busiest_room),
        .o_busiest_count (o_busiest_count)
    );

    room_booking_checker #(.MAX_ROOMS(MAX_ROOMS)) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_valid         (i_valid),
        .i_ready_in      (o_ready),
        .i_start_time    (i_start_time),
        .i_end_time      (i_end_time),
        .i_out_valid     (o_valid),
        .i_ready         (i_ready),
        .i_room          (o_room),
        .i_delayed       (o_delayed),
        .i_actual_start  (o_actual_start),
        .i_actual_end    (o_actual_end),
        .i_busiest_room  (o_busiest_room),
        .i_busiest_count (o_busiest_count),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    always #2 i_clk = ~i_clk;

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == RUN_LIMIT) begin
            $display("room_scheduler_busiest verification failed");
            $finish;
        end
    end

    // Result side: random stalls, one long hold-off to back up the block
    always @(posedge i_clk) begin
        if (o_valid && i_ready) begin
            results_taken <= results_taken + 1;
        end
        if (hold_left != 0) begin
            i_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!hold_done && results_taken == 300) begin
            i_ready   <= 1'b0;
            hold_left <= 400;
            hold_done <= 1'b1;
        end else begin
            i_ready <= calm || ($urandom_range(99) >= 25);
        end
    end

    // Offer one request and hold it until the transfer
    task automatic send_request(input logic [START_W-1:0] req_start,
                                input logic [START_W-1:0] req_end);
        while (!calm && $urandom_range(99) < 25) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_start_time <= req_start;
        i_end_time   <= req_end;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Stop offering and let every open request come back
    task automatic wait_idle();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_rooms(input logic [CFG_W-1:0] value);
        wait_idle();
        i_cfg_wdata <= value;
        i_cfg_we    <= 1'b1;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Rising starts sized to keep the rooms near full, plus out-of-order noise
    task automatic run_bookings(input logic [CFG_W-1:0] rooms);
        int                 active;
        int                 step_max;
        logic [START_W-1:0] req_start;
        logic [START_W-1:0] req_end;
        set_rooms(rooms);
        active     = (rooms == 0) ? 1 : ((rooms > MAX_ROOMS) ? MAX_ROOMS : rooms);
        step_max   = 240 / active + 1;
        sched_time = sched_time + 5000;
        repeat (PHASE_ITEMS) begin
            if ($urandom_range(99) < 12) begin
                req_start = $urandom_range(sched_time, 0);
                req_end   = $urandom;
                if (req_end > req_start) begin
                    req_end = req_start + $urandom_range(300, 0);
                end
            end else begin
                sched_time = sched_time + $urandom_range(step_max, 0);
                req_start  = sched_time;
                req_end    = req_start + $urandom_range(200, 0);
                if ($urandom_range(99) < 5) begin
                    req_end = req_start - $urandom_range(50, 0);
                end
            end
            send_request(req_start, req_end);
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // All sixteen rooms: zero duration, short spans, end before start
        send_request(32'h0, 32'h0);
        send_request(32'h0, 32'h1);
        send_request(32'h0, 32'h5);
        send_request(32'h3, 32'h2);

        // Room count zero acts as one room: fill it, then postpone behind it
        set_rooms(5'd0);
        send_request(32'hA, 32'hFFFF_FFFF);
        send_request(32'h14, 32'h1E);
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(32'h5, 32'h0);

        // Oversized room count acts as the maximum
        set_rooms(5'd31);
        send_request(32'h8000_0000, 32'h8000_0010);

        // Two rooms both busy: postpone to the earlier one
        set_rooms(5'd2);
        send_request(32'h8000_0000, 32'h8000_0100);

        // Three rooms: tie on free time, then a room free exactly at the start
        set_rooms(5'd3);
        send_request(32'h8000_0000, 32'h8000_0110);
        send_request(32'h8000_0001, 32'h8000_0002);
        send_request(32'h8000_0110, 32'h8000_0120);

        for (int p = 0; p < PHASES; p++) begin
            calm <= (p == 4);
            run_bookings(plan[p]);
        end
        calm <= 1'b0;

        wait_idle();
        if (fail_count == 0 && pending == 0) begin
            $display("room_scheduler_busiest verification clean");
        end else begin
            $display("room_scheduler_busiest verification failed");
        end
        $finish;
    end

endmodule
